FILE: design/bsst_pkg.sv
package bsst_pkg;

    localparam int DEF_MAX_SPANS   = 16;
    localparam int DEF_OFFSET_BITS = 48;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_COVER   = 2'd1,
        OP_MISSING = 2'd2,
        OP_CLEAR   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_UP   = 2'd1,
        CELL_DOWN = 2'd2,
        CELL_CLR  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     gap_mode;
    } cell_cmd_t;

    typedef struct packed {
        logic valid;
        logic after;
        logic hit;
    } cell_flags_t;

endpackage

FILE: design/bsst_cell.sv
module bsst_cell
    import bsst_pkg::*;
#(
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cell_cmd_t                     cmd,
    input  logic signed [OFFSET_BITS-1:0] key,
    input  logic signed [OFFSET_BITS-1:0] q_stop,
    input  logic        [OFFSET_BITS-2:0] new_start,
    input  logic        [OFFSET_BITS-2:0] new_stop,
    input  logic        [OFFSET_BITS-2:0] below_start,
    input  logic        [OFFSET_BITS-2:0] below_stop,
    input  logic                          below_valid,
    input  logic                          below_after,
    input  logic        [OFFSET_BITS-2:0] above_start,
    input  logic        [OFFSET_BITS-2:0] above_stop,
    input  logic                          above_valid,
    output logic        [OFFSET_BITS-2:0] start,
    output logic        [OFFSET_BITS-2:0] stop,
    output cell_flags_t                   flags
);

    logic [OFFSET_BITS-2:0]        start_reg, start_next;
    logic [OFFSET_BITS-2:0]        stop_reg, stop_next;
    logic                          valid_reg, valid_next;
    logic signed [OFFSET_BITS-1:0] start_s;
    logic signed [OFFSET_BITS-1:0] stop_s;
    logic                          skip;

    assign start_s = $signed({1'b0, start_reg});
    assign stop_s  = $signed({1'b0, stop_reg});
    assign skip    = valid_reg && (cmd.gap_mode ? (stop_s <= key) : (stop_s < key));

    assign flags.valid = valid_reg;
    assign flags.after = !skip;
    assign flags.hit   = valid_reg && (start_s <= key) && (q_stop <= stop_s);
    assign start       = start_reg;
    assign stop        = stop_reg;

    always_comb
    begin
        start_next = start_reg;
        stop_next  = stop_reg;
        valid_next = valid_reg;
        case (cmd.op)
            CELL_UP:
            begin
                if (below_after)
                begin
                    start_next = below_start;
                    stop_next  = below_stop;
                    valid_next = below_valid;
                end
                else if (!skip)
                begin
                    start_next = new_start;
                    stop_next  = new_stop;
                    valid_next = 1'b1;
                end
            end
            CELL_DOWN:
            begin
                if (!skip)
                begin
                    start_next = above_start;
                    stop_next  = above_stop;
                    valid_next = above_valid;
                end
            end
            CELL_CLR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        stop_reg  <= stop_next;
    end

endmodule

FILE: design/byte_span_set_tracker_top.sv
// Keeps up to MAX_SPANS sorted, disjoint byte spans in a row of cells, one span per cell,
// and walks them with a sequencer that takes one step per cycle. An add steps through S_ADD
// once for every stored span that it absorbs and once more to insert the merged span or to
// report a full table, then replies from S_REPLY; a cover query passes through S_COVER to
// S_REPLY; a clear, a rejected or empty add and a rejected or empty missing query go
// straight to S_REPLY. A missing query gives one result beat per gap, each from its own
// step of the walk, and first steps over a stored span when the window opens inside one.
// Every other input beat gives exactly one result beat. The block handles one item at a
// time: a new input beat is taken at the earliest at the edge after the last result of the
// current one has been loaded into the output register, and a stalled output stalls the
// sequencer.
module byte_span_set_tracker_top
    import bsst_pkg::*;
#(
    parameter int MAX_SPANS   = DEF_MAX_SPANS,
    parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             opcode,
    input  logic [OFFSET_BITS-1:0] range_start,
    input  logic [OFFSET_BITS-1:0] range_stop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic                   covered,
    output logic [OFFSET_BITS-2:0] gap_start,
    output logic [OFFSET_BITS-2:0] gap_stop,
    output logic                   no_gap,
    output logic [OFFSET_BITS-2:0] prefix_end,
    output logic [OFFSET_BITS-2:0] covered_total,
    output logic                   last_result
);

    localparam int W = OFFSET_BITS - 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_COVER = 5'b00100,
        S_GAP   = 5'b01000,
        S_REPLY = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic signed [OFFSET_BITS-1:0] qs_reg, qs_next;
    logic signed [OFFSET_BITS-1:0] qe_reg, qe_next;
    logic [W-1:0]                  total_reg, total_next;
    logic [1:0]                    rsp_status_reg, rsp_status_next;
    logic                          rsp_cov_reg, rsp_cov_next;
    logic                          rsp_nogap_reg, rsp_nogap_next;

    logic                          out_valid_reg;
    logic [1:0]                    out_status_reg;
    logic                          out_cov_reg;
    logic [W-1:0]                  out_gs_reg;
    logic [W-1:0]                  out_ge_reg;
    logic                          out_nogap_reg;
    logic [W-1:0]                  out_prefix_reg;
    logic [W-1:0]                  out_total_reg;
    logic                          out_last_reg;

    cell_cmd_t                     cmd;
    cell_flags_t                   flg [MAX_SPANS];
    logic [W-1:0]                  c_start [MAX_SPANS];
    logic [W-1:0]                  c_stop [MAX_SPANS];
    logic [MAX_SPANS-1:0]          vld;
    logic [MAX_SPANS-1:0]          aft;
    logic [MAX_SPANS-1:0]          hits;
    logic [MAX_SPANS-1:0]          first;
    logic [MAX_SPANS-1:0]          vld_inc;

    logic [W-1:0]                  f_start, f_stop;
    logic                          f_found;
    logic signed [OFFSET_BITS-1:0] f_start_s, f_stop_s;
    logic signed [OFFSET_BITS-1:0] in_s, in_e;

    logic                          out_free;
    logic                          accept;
    logic                          emit;
    logic [1:0]                    e_status;
    logic                          e_cov;
    logic [W-1:0]                  e_gs, e_ge;
    logic                          e_nogap;
    logic                          e_last;
    logic [W-1:0]                  prefix;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SPANS; gi++)
        begin : g_cell
            logic [W-1:0] b_start, b_stop, a_start, a_stop;
            logic         b_valid, b_after, a_valid;
            if (gi == 0)
            begin : g_first
                assign b_start = '0;
                assign b_stop  = '0;
                assign b_valid = 1'b0;
                assign b_after = 1'b0;
                assign first[gi] = aft[gi];
            end
            else
            begin : g_mid
                assign b_start = c_start[gi-1];
                assign b_stop  = c_stop[gi-1];
                assign b_valid = vld[gi-1];
                assign b_after = aft[gi-1];
                assign first[gi] = aft[gi] && !aft[gi-1];
            end
            if (gi == MAX_SPANS - 1)
            begin : g_top
                assign a_start = '0;
                assign a_stop  = '0;
                assign a_valid = 1'b0;
            end
            else
            begin : g_low
                assign a_start = c_start[gi+1];
                assign a_stop  = c_stop[gi+1];
                assign a_valid = vld[gi+1];
            end

            bsst_cell #(
                .OFFSET_BITS (OFFSET_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key         (qs_reg),
                .q_stop      (qe_reg),
                .new_start   (qs_reg[W-1:0]),
                .new_stop    (qe_reg[W-1:0]),
                .below_start (b_start),
                .below_stop  (b_stop),
                .below_valid (b_valid),
                .below_after (b_after),
                .above_start (a_start),
                .above_stop  (a_stop),
                .above_valid (a_valid),
                .start       (c_start[gi]),
                .stop        (c_stop[gi]),
                .flags       (flg[gi])
            );

            assign vld[gi]  = flg[gi].valid;
            assign aft[gi]  = flg[gi].after;
            assign hits[gi] = flg[gi].hit;
        end
    endgenerate

    always_comb
    begin
        f_start = '0;
        f_stop  = '0;
        f_found = 1'b0;
        for (int i = 0; i < MAX_SPANS; i++)
        begin
            f_start = f_start | (c_start[i] & {W{first[i]}});
            f_stop  = f_stop | (c_stop[i] & {W{first[i]}});
            f_found = f_found | (first[i] & vld[i]);
        end
    end

    assign f_start_s = $signed({1'b0, f_start});
    assign f_stop_s  = $signed({1'b0, f_stop});
    assign in_s      = $signed(range_start);
    assign in_e      = $signed(range_stop);
    assign vld_inc   = vld + MAX_SPANS'(1);

    assign prefix   = (vld[0] && (c_start[0] == '0)) ? c_stop[0] : '0;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        qs_next         = qs_reg;
        qe_next         = qe_reg;
        total_next      = total_reg;
        rsp_status_next = rsp_status_reg;
        rsp_cov_next    = rsp_cov_reg;
        rsp_nogap_next  = rsp_nogap_reg;
        cmd.op          = CELL_HOLD;
        cmd.gap_mode    = (state_reg == S_GAP);
        emit            = 1'b0;
        e_status        = ST_OK;
        e_cov           = 1'b0;
        e_gs            = '0;
        e_ge            = '0;
        e_nogap         = 1'b0;
        e_last          = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    qs_next         = in_s;
                    qe_next         = in_e;
                    rsp_status_next = ST_OK;
                    rsp_cov_next    = 1'b0;
                    rsp_nogap_next  = 1'b0;
                    state_next      = S_REPLY;
                    case (opcode)
                        OP_ADD:
                        begin
                            if (in_s < 0 || in_e < 0 || in_e < in_s)
                            begin
                                rsp_status_next = ST_BAD;
                            end
                            else if (in_e != in_s)
                            begin
                                state_next = S_ADD;
                            end
                        end
                        OP_COVER:
                        begin
                            state_next = S_COVER;
                        end
                        OP_MISSING:
                        begin
                            if (in_s < 0 || in_e < 0)
                            begin
                                rsp_status_next = ST_BAD;
                            end
                            else if (in_e <= in_s)
                            begin
                                rsp_nogap_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_GAP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.op     = CELL_CLR;
                            total_next = '0;
                        end
                        default:
                        begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (f_found && (f_start_s <= qe_reg))
                begin
                    cmd.op     = CELL_DOWN;
                    total_next = total_reg - (f_stop - f_start);
                    if (f_start_s < qs_reg)
                    begin
                        qs_next = f_start_s;
                    end
                    if (f_stop_s > qe_reg)
                    begin
                        qe_next = f_stop_s;
                    end
                end
                else if (vld[MAX_SPANS-1])
                begin
                    rsp_status_next = ST_FULL;
                    state_next      = S_REPLY;
                end
                else
                begin
                    cmd.op     = CELL_UP;
                    total_next = total_reg + (qe_reg[W-1:0] - qs_reg[W-1:0]);
                    state_next = S_REPLY;
                end
            end
            S_COVER:
            begin
                rsp_cov_next = (qe_reg <= qs_reg) || (|hits);
                state_next   = S_REPLY;
            end
            S_GAP:
            begin
                if (out_free)
                begin
                    if (!f_found || (f_start_s >= qe_reg))
                    begin
                        emit       = 1'b1;
                        e_gs       = qs_reg[W-1:0];
                        e_ge       = qe_reg[W-1:0];
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        qs_next = f_stop_s;
                        if (f_start_s > qs_reg)
                        begin
                            emit   = 1'b1;
                            e_gs   = qs_reg[W-1:0];
                            e_ge   = f_start;
                            e_last = (f_stop_s >= qe_reg);
                            if (e_last)
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        else if (f_stop_s >= qe_reg)
                        begin
                            emit       = 1'b1;
                            e_nogap    = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_status   = rsp_status_reg;
                    e_cov      = rsp_cov_reg;
                    e_nogap    = rsp_nogap_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        qs_reg         <= qs_next;
        qe_reg         <= qe_next;
        rsp_status_reg <= rsp_status_next;
        rsp_cov_reg    <= rsp_cov_next;
        rsp_nogap_reg  <= rsp_nogap_next;
        if (out_free && emit)
        begin
            out_status_reg <= e_status;
            out_cov_reg    <= e_cov;
            out_gs_reg     <= e_gs;
            out_ge_reg     <= e_ge;
            out_nogap_reg  <= e_nogap;
            out_prefix_reg <= prefix;
            out_total_reg  <= total_reg;
            out_last_reg   <= e_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign covered       = out_cov_reg;
    assign gap_start     = out_gs_reg;
    assign gap_stop      = out_ge_reg;
    assign no_gap        = out_nogap_reg;
    assign prefix_end    = out_prefix_reg;
    assign covered_total = out_total_reg;
    assign last_result   = out_last_reg;

    // Stored spans always fill the low cells without holes.
    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (vld & vld_inc) == '0)
        else $error("span cells are not packed from cell zero");

    // A result that is not the last one can only come from the gap walk.
    a_mid_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (state_reg == S_GAP))
        else $error("non-final result outside the gap walk");

    // An empty table covers no bytes.
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        !vld[0] |-> (total_reg == '0))
        else $error("covered total is nonzero with an empty table");

endmodule
